[rtl/tea_pkg.sv]
// Shared types, constants and the round function for the TEA block cipher.
// Used by tea_half_round and tea_block_cipher_triple; depends on nothing.
`default_nettype none

package tea_pkg;

    // Default cycle count of one TEA pass
    localparam int CYCLES = 32;

    // Number of chained passes in triple mode
    localparam int PASSES = 3;

    // Per-cycle sum increment
    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_KEY0_01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY0_23 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY1_01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY1_23 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY2_01 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KEY2_23 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TRIPLE  = 3'd6;

    // Opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // 128-bit key: word 0 in [127:96] down to word 3 in [31:0]
    typedef logic [127:0] key_t;
    typedef logic [PASSES-1:0][127:0] key_set_t;

    // One item as it travels down the pipeline
    typedef struct packed {
        logic        valid;
        logic        op;
        logic [31:0] y;
        logic [31:0] z;
    } stage_t;

    // TEA mixing function for one half-update
    function automatic logic [31:0] mix(
        input logic [31:0] x,
        input logic [31:0] k_lo,
        input logic [31:0] k_hi,
        input logic [31:0] sum
    );
        mix = ((x << 4) + k_lo) ^ (x + sum) ^ ((x >> 5) + k_hi);
    endfunction

endpackage

`default_nettype wire

[rtl/tea_block_cipher_triple.sv]
// Top level of the pipelined TEA / triple-TEA block cipher.
// Depends on tea_pkg and tea_half_round.
//
// Fully unrolled TEA engine: one 64-bit block (left_word, right_word) with an
// opcode enters per clock while the pipeline is not held, and passes through
// every stage into the output buffer. Every TEA cycle is two register stages, one per
// half-update, and the three passes of triple mode are laid out one after the
// other, so the pipeline is 3 * 2 * CYCLES stages long. In single mode the
// second and third passes carry the block through unchanged, so latency does
// not depend on the mode. Results land in a two-entry output buffer; the
// whole pipeline holds only when its last stage has an item and that buffer
// is full. Keys and triple_mode are read live from the register file and must
// only be written while the pipeline is empty.
`default_nettype none

module tea_block_cipher_triple #(
    parameter int CYCLES = tea_pkg::CYCLES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tea_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    // Input items
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          opcode,
    input  wire logic [31:0]                   left_word,
    input  wire logic [31:0]                   right_word,
    // Result items
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [31:0]                        left_result,
    output logic [31:0]                        right_result
);

    localparam int STAGES = tea_pkg::PASSES * 2 * CYCLES;

    // Register file
    logic [63:0] key0_01_reg;
    logic [63:0] key0_23_reg;
    logic [63:0] key1_01_reg;
    logic [63:0] key1_23_reg;
    logic [63:0] key2_01_reg;
    logic [63:0] key2_23_reg;
    logic        triple_reg;
    tea_pkg::key_set_t keys;

    // Pipeline
    tea_pkg::stage_t chain [STAGES+1];
    logic            en;
    logic            v_last;

    // Output buffer
    logic [31:0] buf_y_reg [2];
    logic [31:0] buf_z_reg [2];
    logic        rd_ptr_reg;
    logic        wr_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        full;
    logic        push;
    logic        pop;

    assign cfg_ready = 1'b1;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_01_reg <= '0;
            key0_23_reg <= '0;
            key1_01_reg <= '0;
            key1_23_reg <= '0;
            key2_01_reg <= '0;
            key2_23_reg <= '0;
            triple_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tea_pkg::REG_KEY0_01: key0_01_reg <= cfg_data;
                tea_pkg::REG_KEY0_23: key0_23_reg <= cfg_data;
                tea_pkg::REG_KEY1_01: key1_01_reg <= cfg_data;
                tea_pkg::REG_KEY1_23: key1_23_reg <= cfg_data;
                tea_pkg::REG_KEY2_01: key2_01_reg <= cfg_data;
                tea_pkg::REG_KEY2_23: key2_23_reg <= cfg_data;
                tea_pkg::REG_TRIPLE:  triple_reg  <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign keys[0] = {key0_01_reg, key0_23_reg};
    assign keys[1] = {key1_01_reg, key1_23_reg};
    assign keys[2] = {key2_01_reg, key2_23_reg};

    // Pipeline advances unless a finished item cannot be buffered
    assign v_last   = chain[STAGES].valid;
    assign full     = (count_reg == 2'd2);
    assign en       = !v_last || !full;
    assign in_ready = en;

    assign chain[0].valid = in_valid;
    assign chain[0].op    = opcode;
    assign chain[0].y     = left_word;
    assign chain[0].z     = right_word;

    // Stage s handles pass p, cycle n, half h
    generate
        for (genvar p = 0; p < tea_pkg::PASSES; p++)
        begin : g_pass
            for (genvar n = 0; n < CYCLES; n++)
            begin : g_cyc
                for (genvar h = 0; h < 2; h++)
                begin : g_half
                    tea_half_round #(
                        .CYCLES  (CYCLES),
                        .PASS    (p),
                        .CYC_IDX (n),
                        .HALF    (h)
                    ) u_stage (
                        .clk       (clk),
                        .rst_n     (rst_n),
                        .en        (en),
                        .triple    (triple_reg),
                        .keys      (keys),
                        .stage_in  (chain[p*2*CYCLES + 2*n + h]),
                        .stage_out (chain[p*2*CYCLES + 2*n + h + 1])
                    );
                end
            end
        end
    endgenerate

    // Two-entry output buffer
    assign push = en && v_last;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_y_reg[wr_ptr_reg] <= chain[STAGES].y;
            buf_z_reg[wr_ptr_reg] <= chain[STAGES].z;
        end
    end

    assign out_valid    = (count_reg != 2'd0);
    assign left_result  = buf_y_reg[rd_ptr_reg];
    assign right_result = buf_z_reg[rd_ptr_reg];

    // Buffer never holds more than two items
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // Intake only stalls on a finished item facing a full buffer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v_last && full))
        else $error("pipeline stalled without cause");

    // A held finished item is not lost
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (v_last && !en) |=> v_last)
        else $error("stalled item dropped from last stage");

    // A push into a full buffer never happens
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full output buffer");

endmodule

`default_nettype wire

[rtl/tea_half_round.sv]
// One pipeline stage of TEA: a single Feistel half-update, encrypt or decrypt.
// Depends on tea_pkg.
`default_nettype none

module tea_half_round #(
    parameter int CYCLES  = tea_pkg::CYCLES,
    parameter int PASS    = 0,
    parameter int CYC_IDX = 0,
    parameter int HALF    = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              triple,
    input  wire tea_pkg::key_set_t keys,
    input  wire tea_pkg::stage_t   stage_in,
    output tea_pkg::stage_t        stage_out
);

    // Running sum seen by this cycle in each direction
    localparam logic [31:0] SUM_ENC = 32'(tea_pkg::DELTA * 32'(CYC_IDX + 1));
    localparam logic [31:0] SUM_DEC = 32'(tea_pkg::DELTA * 32'(CYCLES - CYC_IDX));
    localparam int          DEC_KEY = tea_pkg::PASSES - 1 - PASS;

    logic        valid_reg;
    logic        op_reg;
    logic [31:0] y_reg;
    logic [31:0] z_reg;
    logic [31:0] y_next;
    logic [31:0] z_next;
    logic        active;
    logic        dec;
    logic [31:0] sum;
    tea_pkg::key_t key;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] kc;
    logic [31:0] kd;

    // Pass 0 always works; later passes only in triple mode
    assign active = (PASS == 0) || triple;
    assign dec    = (stage_in.op == tea_pkg::OP_DECRYPT);
    assign sum    = dec ? SUM_DEC : SUM_ENC;

    // Encrypt uses keys 0,1,2 in order; decrypt 2,1,0 (or key 0 alone)
    always_comb
    begin
        if (dec)
        begin
            key = triple ? keys[DEC_KEY] : keys[0];
        end
        else
        begin
            key = keys[PASS];
        end
    end

    assign ka = key[127:96];
    assign kb = key[95:64];
    assign kc = key[63:32];
    assign kd = key[31:0];

    // Half-update: encrypt does y then z, decrypt does z then y
    generate
        if (HALF == 0)
        begin : g_first
            always_comb
            begin
                y_next = stage_in.y;
                z_next = stage_in.z;
                if (active)
                begin
                    if (dec)
                    begin
                        z_next = stage_in.z - tea_pkg::mix(stage_in.y, kc, kd, sum);
                    end
                    else
                    begin
                        y_next = stage_in.y + tea_pkg::mix(stage_in.z, ka, kb, sum);
                    end
                end
            end
        end
        else
        begin : g_second
            always_comb
            begin
                y_next = stage_in.y;
                z_next = stage_in.z;
                if (active)
                begin
                    if (dec)
                    begin
                        y_next = stage_in.y - tea_pkg::mix(stage_in.z, ka, kb, sum);
                    end
                    else
                    begin
                        z_next = stage_in.z + tea_pkg::mix(stage_in.y, kc, kd, sum);
                    end
                end
            end
        end
    endgenerate

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg <= stage_in.op;
            y_reg  <= y_next;
            z_reg  <= z_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.op    = op_reg;
    assign stage_out.y     = y_reg;
    assign stage_out.z     = z_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for tea_block_cipher_triple: single and triple TEA, both directions.
// A built-in TEA predictor checks every result. Depends on tea_pkg and the cipher RTL.
`timescale 1ns / 1ps

module tb_top;
    import tea_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int CLK_PERIOD     = 2 * HALF_PERIOD;
    localparam int RESET_CYCLES   = 6;
    localparam int PIPE_LATENCY   = 6 * CYCLES + 1;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 115;
    localparam int MAX_REPORTS    = 10;

    // Index with no register behind it; writes there are dropped
    localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic        op;
        logic [31:0] lw;
        logic [31:0] rw;
    } block_item_t;

    typedef struct packed {
        logic        op;
        logic [31:0] lin;
        logic [31:0] rin;
        logic [31:0] lout;
        logic [31:0] rout;
    } cipher_expect_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] idx;
        logic [63:0]          data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = OP_ENCRYPT;
    logic [31:0] left_word = '0;
    logic [31:0] right_word = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] left_result;
    logic [31:0] right_result;

    // Stimulus and expectation stores
    block_item_t    block_backlog[$];
    reg_write_t     cfg_backlog[$];
    cipher_expect_t predicted_results[$];

    // Predictor copy of the register file
    logic [63:0] key_regs [0:5] = '{default: '0};
    logic        triple_sel = 1'b0;

    int  error_count = 0;
    int  in_gap = 0;
    int  out_hold = 0;
    bit  quiet = 1'b0;

    tea_block_cipher_triple #(
        .CYCLES(CYCLES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .left_word   (left_word),
        .right_word  (right_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_result (left_result),
        .right_result(right_result)
    );

    always #HALF_PERIOD clk = ~clk;

    // One TEA pass over a 64-bit block with a 128-bit key
    function automatic logic [63:0] tea_pass(input logic [63:0] blk, input key_t k,
                                             input logic op);
        logic [31:0] y, z, sum, a, b, c, d;
        int n;
        y = blk[63:32];
        z = blk[31:0];
        a = k[127:96];
        b = k[95:64];
        c = k[63:32];
        d = k[31:0];
        if (op == OP_ENCRYPT) begin
            sum = '0;
            for (n = 0; n < CYCLES; n++) begin
                sum = sum + DELTA;
                y = y + ((((z << 4) + a) ^ (z + sum)) ^ ((z >> 5) + b));
                z = z + ((((y << 4) + c) ^ (y + sum)) ^ ((y >> 5) + d));
            end
        end else begin
            sum = DELTA * CYCLES;
            for (n = 0; n < CYCLES; n++) begin
                z = z - ((((y << 4) + c) ^ (y + sum)) ^ ((y >> 5) + d));
                y = y - ((((z << 4) + a) ^ (z + sum)) ^ ((z >> 5) + b));
                sum = sum - DELTA;
            end
        end
        return {y, z};
    endfunction

    // Full cipher under the current mode and keys
    function automatic logic [63:0] cipher_block(input logic op, input logic [63:0] blk);
        logic [63:0] acc;
        int k;
        acc = blk;
        if (!triple_sel) begin
            acc = tea_pass(acc, {key_regs[0], key_regs[1]}, op);
        end else if (op == OP_ENCRYPT) begin
            for (k = 0; k < PASSES; k++)
                acc = tea_pass(acc, {key_regs[2*k], key_regs[2*k+1]}, op);
        end else begin
            for (k = PASSES - 1; k >= 0; k--)
                acc = tea_pass(acc, {key_regs[2*k], key_regs[2*k+1]}, op);
        end
        return acc;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(40, 20);
    endfunction

    // Mostly random words, sometimes the corners
    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return 32'h0000_0000;
        else if (roll < 8)
            return 32'hFFFF_FFFF;
        else if (roll < 12)
            return 32'h1 << $urandom_range(31);
        return $urandom();
    endfunction

    function automatic logic [63:0] pick_key_half();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 64'h0;
        else if (roll < 20)
            return {64{1'b1}};
        return {$urandom(), $urandom()};
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic queue_block(input logic op, input logic [31:0] lw, input logic [31:0] rw);
        block_item_t item;
        item.op = op;
        item.lw = lw;
        item.rw = rw;
        block_backlog.push_back(item);
    endtask

    task automatic queue_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
        reg_write_t w;
        w.idx = idx;
        w.data = data;
        cfg_backlog.push_back(w);
    endtask

    // Wait until all register writes have gone through
    task automatic commit_settings();
        while (cfg_backlog.size() > 0 || cfg_valid)
            @(negedge clk);
    endtask

    // Wait until every queued item has come back
    task automatic drain();
        while (block_backlog.size() > 0 || in_valid || predicted_results.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register write driver; predictor copy follows each accepted write
    always @(posedge clk) begin : cfg_driver
        reg_write_t w;
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_TRIPLE)
                    triple_sel = cfg_data[0];
                else if (cfg_index != REG_NONE)
                    key_regs[cfg_index] = cfg_data;
            end
            if (!cfg_valid || cfg_ready) begin
                if (cfg_backlog.size() > 0) begin
                    w = cfg_backlog.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data  <= w.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Block driver; predicts the result of each accepted item
    always @(posedge clk) begin : block_driver
        block_item_t    item;
        cipher_expect_t e;
        logic [63:0]    blk;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                blk = cipher_block(opcode, {left_word, right_word});
                e.op   = opcode;
                e.lin  = left_word;
                e.rin  = right_word;
                e.lout = blk[63:32];
                e.rout = blk[31:0];
                predicted_results.push_back(e);
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (block_backlog.size() > 0) begin
                    item = block_backlog.pop_front();
                    in_valid   <= 1'b1;
                    opcode     <= item.op;
                    left_word  <= item.lw;
                    right_word <= item.rw;
                    in_gap = quiet ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk) begin : result_monitor
        cipher_expect_t e;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_hold = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (predicted_results.size() == 0) begin
                    note_failure($sformatf("result %h_%h with none expected",
                                           left_result, right_result));
                end else begin
                    e = predicted_results.pop_front();
                    if (left_result !== e.lout)
                        note_failure($sformatf(
                            "left_result op=%0d in=%h_%h expected %h got %h",
                            e.op, e.lin, e.rin, e.lout, left_result));
                    if (right_result !== e.rout)
                        note_failure($sformatf(
                            "right_result op=%0d in=%h_%h expected %h got %h",
                            e.op, e.lin, e.rin, e.rout, right_result));
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(99) < 20)
                    out_hold = pick_gap();
            end
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        int p, i, r;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: zero keys, single mode
        queue_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Single mode with all-ones key 0; keys 1 and 2 must not matter.
        // Mode write carries junk above bit 0, plus a write to the empty index.
        queue_write(REG_KEY0_01, {64{1'b1}});
        queue_write(REG_KEY0_23, {64{1'b1}});
        queue_write(REG_KEY1_01, {$urandom(), $urandom()});
        queue_write(REG_KEY1_23, {$urandom(), $urandom()});
        queue_write(REG_KEY2_01, {$urandom(), $urandom()});
        queue_write(REG_KEY2_23, {$urandom(), $urandom()});
        queue_write(REG_TRIPLE, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_write(REG_NONE, {64{1'b1}});
        commit_settings();
        queue_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        queue_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        queue_block(OP_ENCRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_block(OP_DECRYPT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        queue_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_block(OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        drain();

        // Triple mode, key 0 all ones and keys 1 and 2 random; mode data has high bits set
        queue_write(REG_TRIPLE, 64'h8000_0000_0000_0001);
        queue_write(REG_NONE, {$urandom(), $urandom()});
        commit_settings();
        queue_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_ENCRYPT, $urandom(), $urandom());
        queue_block(OP_DECRYPT, $urandom(), $urandom());
        drain();

        // Triple mode, every key all ones, no idling
        quiet = 1'b1;
        for (r = REG_KEY1_01; r <= REG_KEY2_23; r++)
            queue_write(r[REG_IDX_W-1:0], {64{1'b1}});
        commit_settings();
        queue_block(OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_block(OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
        queue_block(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
        drain();
        quiet = 1'b0;

        // Triple mode, every key zero
        for (r = REG_KEY0_01; r <= REG_KEY2_23; r++)
            queue_write(r[REG_IDX_W-1:0], 64'h0);
        commit_settings();

        // Random phases: after the first, each key half is rewritten with 80% chance, and the mode each time
        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p > 0) begin
                for (r = REG_KEY0_01; r <= REG_KEY2_23; r++)
                    if ($urandom_range(99) < 80)
                        queue_write(r[REG_IDX_W-1:0], pick_key_half());
                queue_write(REG_TRIPLE, {$urandom(), $urandom()});
                if ($urandom_range(99) < 25)
                    queue_write(REG_NONE, {$urandom(), $urandom()});
                commit_settings();
            end
            quiet = (p % 4 == 3);
            for (i = 0; i < PHASE_ITEMS; i++)
                queue_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT,
                            pick_word(), pick_word());
            drain();
        end

        // Catch stray results after the last one
        repeat (PIPE_LATENCY + 10) @(negedge clk);
        if (error_count == 0 && predicted_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/tea_pkg.sv
rtl/tea_half_round.sv
rtl/tea_block_cipher_triple.sv
tb/tb_top.sv
